// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prac_pkg.sv =====
// Package for the protected range access checker: request and status codes,
// sequencer states and default sizes. No dependencies.
`timescale 1ns / 1ps

package prac_pkg;

    localparam int unsigned MAX_RANGES_DEF = 64;
    localparam int unsigned COUNT_OUT_W    = 7;
    localparam logic [63:0] TASK_LIMIT_RST = 64'h0000_8000_0000_0000;

    localparam logic [3:0] REQ_LOAD      = 4'd0;
    localparam logic [3:0] REQ_FINISH    = 4'd1;
    localparam logic [3:0] REQ_ENTER     = 4'd2;
    localparam logic [3:0] REQ_EXIT      = 4'd3;
    localparam logic [3:0] REQ_SUSPEND   = 4'd4;
    localparam logic [3:0] REQ_RESUME    = 4'd5;
    localparam logic [3:0] REQ_RST_DEPTH = 4'd6;
    localparam logic [3:0] REQ_GATED_CHK = 4'd7;
    localparam logic [3:0] REQ_RAW_CHK   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_UNSORTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LD_EMPTY,
        S_LD_SORT,
        S_LD_MERGE,
        S_LD_MAX,
        S_CHK_LIM,
        S_CHK_ADD,
        S_CHK_END,
        S_SRCH,
        S_SRCH_CMP,
        S_FIN_CMP,
        S_DONE
    } state_t;

endpackage

// ===== design/protected_range_access_checker.sv =====
// Protected range access checker top level: range table load/merge, nesting
// depth and binary-search access check on one shared 65-bit adder.
// Depends on prac_pkg and assert_macros.svh.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------
//  request   | start / busy            | req_type, address, length, range_end, depth_in
//  result    | done (one-cycle strobe) | allowed, status, depth_out, range_count
//  config    | cfg_valid / cfg_ready   | cfg_data (task_limit)
//
// The strobe follows the execute state directly for depth, finish, unused and
// zero-length or depth-gated checks. Loads add the empty, sort, merge and max tests, other
// checks the limit, add and end compares, binary search and final compare on the one adder,
// each as needed. busy drops after each strobe before the next transfer.
// Reset is asynchronous and clears all control state; the table has no reset.
// The result strobe cannot be stalled; cfg_ready is high only while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module protected_range_access_checker #(
    parameter int unsigned MAX_RANGES = prac_pkg::MAX_RANGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  req_type,
    input  logic [63:0] address,
    input  logic [63:0] length,
    input  logic [63:0] range_end,
    input  logic [15:0] depth_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic        allowed,
    output logic [2:0]  status,
    output logic [15:0] depth_out,
    output logic [prac_pkg::COUNT_OUT_W-1:0] range_count
);

    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

    prac_pkg::state_t state_reg, state_next;

    logic [3:0]        req_reg, req_next;
    logic [63:0]       addr_reg, addr_next;
    logic [63:0]       len_reg, len_next;
    logic [63:0]       rend_reg, rend_next;
    logic [15:0]       dep_in_reg, dep_in_next;
    logic [63:0]       limit_reg;
    logic [63:0]       end_reg, end_next;
    logic [63:0]       prev_reg, prev_next;
    logic [63:0]       last_end_reg, last_end_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic [CNT_W-1:0]  committed_reg, committed_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [2:0]        err_reg, err_next;
    logic              loading_reg, loading_next;
    logic [15:0]       depth_reg, depth_next;
    logic [15:0]       res_depth_reg, res_depth_next;
    logic              allowed_reg, allowed_next;
    logic [2:0]        status_reg, status_next;

    // shared adder / comparator
    logic [63:0] unit_a, unit_b;
    logic        unit_sub;
    logic [64:0] unit_sum;
    logic        unit_lt;

    // table
    logic [63:0]      starts_mem [MAX_RANGES];
    logic [63:0]      ends_mem   [MAX_RANGES];
    logic [63:0]      starts_q, ends_q;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             we_start, we_end;
    logic [IDX_W-1:0] wr_idx;

    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] last_idx_full;
    logic [CNT_W-1:0] lo_plus1;
    logic [CNT_W+prac_pkg::COUNT_OUT_W-1:0] cnt_ext;
    logic             accept;
    logic             is_check;

    assign accept        = start && (state_reg == prac_pkg::S_IDLE);
    assign is_check      = (req_reg == prac_pkg::REQ_GATED_CHK) ||
                           (req_reg == prac_pkg::REQ_RAW_CHK);
    assign mid_calc      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_idx_full = pend_reg - CNT_W'(1);
    assign lo_plus1      = mid_reg + CNT_W'(1);

    assign unit_sum = {1'b0, unit_a} + {1'b0, unit_b ^ {64{unit_sub}}} + 65'(unit_sub);
    assign unit_lt  = ~unit_sum[64];

    // operand select for the shared unit
    always_comb
    begin
        unit_a   = addr_reg;
        unit_b   = limit_reg;
        unit_sub = 1'b1;
        case (state_reg)
            prac_pkg::S_LD_EMPTY:
            begin
                unit_a = addr_reg;
                unit_b = rend_reg;
            end
            prac_pkg::S_LD_SORT:
            begin
                unit_a = addr_reg;
                unit_b = prev_reg;
            end
            prac_pkg::S_LD_MERGE:
            begin
                unit_a = last_end_reg;
                unit_b = addr_reg;
            end
            prac_pkg::S_LD_MAX:
            begin
                unit_a = last_end_reg;
                unit_b = rend_reg;
            end
            prac_pkg::S_CHK_ADD:
            begin
                unit_a   = addr_reg;
                unit_b   = len_reg;
                unit_sub = 1'b0;
            end
            prac_pkg::S_CHK_END:
            begin
                unit_a = limit_reg;
                unit_b = end_reg;
            end
            prac_pkg::S_SRCH_CMP:
            begin
                unit_a = addr_reg;
                unit_b = ends_q;
            end
            prac_pkg::S_FIN_CMP:
            begin
                unit_a = starts_q;
                unit_b = end_reg;
            end
            default:
            begin
                unit_a = addr_reg;
                unit_b = limit_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prac_pkg::S_IDLE:
                if (start)
                    state_next = prac_pkg::S_EXEC;
            prac_pkg::S_EXEC:
            begin
                if (req_reg == prac_pkg::REQ_LOAD)
                    state_next = prac_pkg::S_LD_EMPTY;
                else if (is_check && (len_reg != '0) &&
                         !(req_reg == prac_pkg::REQ_GATED_CHK && depth_reg == '0))
                    state_next = prac_pkg::S_CHK_LIM;
                else
                    state_next = prac_pkg::S_DONE;
            end
            prac_pkg::S_LD_EMPTY:
                state_next = (err_reg != prac_pkg::ST_OK || !unit_lt) ?
                             prac_pkg::S_DONE : prac_pkg::S_LD_SORT;
            prac_pkg::S_LD_SORT:
                state_next = (pend_reg != '0 && unit_lt) ?
                             prac_pkg::S_DONE : prac_pkg::S_LD_MERGE;
            prac_pkg::S_LD_MERGE:
                state_next = (pend_reg != '0 && !unit_lt) ?
                             prac_pkg::S_LD_MAX : prac_pkg::S_DONE;
            prac_pkg::S_LD_MAX:
                state_next = prac_pkg::S_DONE;
            prac_pkg::S_CHK_LIM:
                state_next = unit_lt ? prac_pkg::S_CHK_ADD : prac_pkg::S_DONE;
            prac_pkg::S_CHK_ADD:
                state_next = unit_sum[64] ? prac_pkg::S_DONE : prac_pkg::S_CHK_END;
            prac_pkg::S_CHK_END:
                state_next = unit_lt ? prac_pkg::S_DONE : prac_pkg::S_SRCH;
            prac_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                    state_next = prac_pkg::S_SRCH_CMP;
                else if (lo_reg == committed_reg)
                    state_next = prac_pkg::S_DONE;
                else
                    state_next = prac_pkg::S_FIN_CMP;
            end
            prac_pkg::S_SRCH_CMP:
                state_next = prac_pkg::S_SRCH;
            prac_pkg::S_FIN_CMP:
                state_next = prac_pkg::S_DONE;
            prac_pkg::S_DONE:
                state_next = prac_pkg::S_IDLE;
            default:
                state_next = prac_pkg::S_IDLE;
        endcase
    end

    // datapath next values, table access
    always_comb
    begin
        req_next       = req_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        rend_next      = rend_reg;
        dep_in_next    = dep_in_reg;
        end_next       = end_reg;
        prev_next      = prev_reg;
        last_end_next  = last_end_reg;
        pend_next      = pend_reg;
        committed_next = committed_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        err_next       = err_reg;
        loading_next   = loading_reg;
        depth_next     = depth_reg;
        res_depth_next = res_depth_reg;
        allowed_next   = allowed_reg;
        status_next    = status_reg;
        rd_en          = 1'b0;
        rd_idx         = lo_reg[IDX_W-1:0];
        we_start       = 1'b0;
        we_end         = 1'b0;
        wr_idx         = pend_reg[IDX_W-1:0];

        case (state_reg)
            prac_pkg::S_IDLE:
                if (accept)
                begin
                    req_next    = req_type;
                    addr_next   = address;
                    len_next    = length;
                    rend_next   = range_end;
                    dep_in_next = depth_in;
                end
            prac_pkg::S_EXEC:
            begin
                allowed_next = 1'b0;
                status_next  = prac_pkg::ST_OK;
                case (req_reg)
                    prac_pkg::REQ_LOAD:
                        if (!loading_reg)
                        begin
                            loading_next   = 1'b1;
                            pend_next      = '0;
                            err_next       = prac_pkg::ST_OK;
                            prev_next      = '0;
                            committed_next = '0;
                        end
                    prac_pkg::REQ_FINISH:
                    begin
                        if (err_reg != prac_pkg::ST_OK)
                        begin
                            status_next    = err_reg;
                            committed_next = '0;
                        end
                        else if (pend_reg == '0)
                        begin
                            status_next    = prac_pkg::ST_NONE;
                            committed_next = '0;
                        end
                        else
                            committed_next = pend_reg;
                        pend_next    = '0;
                        err_next     = prac_pkg::ST_OK;
                        loading_next = 1'b0;
                    end
                    prac_pkg::REQ_ENTER:
                        depth_next = depth_reg + 16'd1;
                    prac_pkg::REQ_EXIT:
                        depth_next = depth_reg - 16'd1;
                    prac_pkg::REQ_SUSPEND:
                    begin
                        res_depth_next = depth_reg;
                        depth_next     = '0;
                    end
                    prac_pkg::REQ_RESUME:
                        depth_next = dep_in_reg;
                    prac_pkg::REQ_RST_DEPTH:
                        depth_next = '0;
                    prac_pkg::REQ_GATED_CHK,
                    prac_pkg::REQ_RAW_CHK:
                        if (len_reg == '0 ||
                            (req_reg == prac_pkg::REQ_GATED_CHK && depth_reg == '0))
                            allowed_next = 1'b1;
                    default:
                        allowed_next = 1'b0;
                endcase
            end
            prac_pkg::S_LD_EMPTY:
            begin
                if (err_reg != prac_pkg::ST_OK)
                    status_next = err_reg;
                else if (!unit_lt)
                begin
                    err_next    = prac_pkg::ST_EMPTY;
                    status_next = prac_pkg::ST_EMPTY;
                end
            end
            prac_pkg::S_LD_SORT:
                if (pend_reg != '0 && unit_lt)
                begin
                    err_next    = prac_pkg::ST_UNSORTED;
                    status_next = prac_pkg::ST_UNSORTED;
                end
            prac_pkg::S_LD_MERGE:
                if (!(pend_reg != '0 && !unit_lt))
                begin
                    if (pend_reg == CNT_W'(MAX_RANGES))
                    begin
                        err_next    = prac_pkg::ST_FULL;
                        status_next = prac_pkg::ST_FULL;
                    end
                    else
                    begin
                        we_start      = 1'b1;
                        we_end        = 1'b1;
                        wr_idx        = pend_reg[IDX_W-1:0];
                        pend_next     = pend_reg + CNT_W'(1);
                        last_end_next = rend_reg;
                        prev_next     = addr_reg;
                    end
                end
            prac_pkg::S_LD_MAX:
            begin
                prev_next = addr_reg;
                if (unit_lt)
                begin
                    we_end        = 1'b1;
                    wr_idx        = last_idx_full[IDX_W-1:0];
                    last_end_next = rend_reg;
                end
            end
            prac_pkg::S_CHK_ADD:
                end_next = unit_sum[63:0];
            prac_pkg::S_CHK_END:
            begin
                lo_next = '0;
                hi_next = committed_reg;
            end
            prac_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_calc;
                    rd_en    = 1'b1;
                    rd_idx   = mid_calc[IDX_W-1:0];
                end
                else if (lo_reg == committed_reg)
                    allowed_next = 1'b1;
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = lo_reg[IDX_W-1:0];
                end
            end
            prac_pkg::S_SRCH_CMP:
            begin
                if (unit_lt)
                    hi_next = mid_reg;
                else
                    lo_next = lo_plus1;
            end
            prac_pkg::S_FIN_CMP:
                allowed_next = !unit_lt;
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != prac_pkg::S_IDLE);
        cfg_ready = (state_reg == prac_pkg::S_IDLE);
        done      = (state_reg == prac_pkg::S_DONE);
        allowed   = allowed_reg;
        status    = status_reg;
        depth_out = (req_reg == prac_pkg::REQ_SUSPEND) ? res_depth_reg : depth_reg;
        cnt_ext   = (CNT_W + prac_pkg::COUNT_OUT_W)'((req_reg == prac_pkg::REQ_LOAD) ?
                                                     pend_reg : committed_reg);
        range_count = cnt_ext[prac_pkg::COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prac_pkg::S_IDLE;
            limit_reg     <= prac_pkg::TASK_LIMIT_RST;
            pend_reg      <= '0;
            committed_reg <= '0;
            prev_reg      <= '0;
            err_reg       <= prac_pkg::ST_OK;
            loading_reg   <= 1'b0;
            depth_reg     <= '0;
            req_reg       <= prac_pkg::REQ_FINISH;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            allowed_reg   <= 1'b0;
            status_reg    <= prac_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            committed_reg <= committed_next;
            prev_reg      <= prev_next;
            err_reg       <= err_next;
            loading_reg   <= loading_next;
            depth_reg     <= depth_next;
            req_reg       <= req_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            allowed_reg   <= allowed_next;
            status_reg    <= status_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        len_reg       <= len_next;
        rend_reg      <= rend_next;
        dep_in_reg    <= dep_in_next;
        end_reg       <= end_next;
        last_end_reg  <= last_end_next;
        res_depth_reg <= res_depth_next;
    end

    // range table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we_start)
            starts_mem[wr_idx] <= addr_reg;
        if (we_end)
            ends_mem[wr_idx] <= rend_reg;
        if (rd_en)
        begin
            starts_q <= starts_mem[rd_idx];
            ends_q   <= ends_mem[rd_idx];
        end
    end

    `PRAC_ASSERT_NEXT(a_done_frees, done, !busy, "result strobe not followed by idle")
    `PRAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done,
                      "transfer not followed by work")
    `PRAC_ASSERT_NOW(a_counts_bounded,
                     1'b1,
                     pend_reg <= CNT_W'(MAX_RANGES) && committed_reg <= CNT_W'(MAX_RANGES),
                     "range count beyond table size")
    `PRAC_ASSERT_NOW(a_search_window, state_reg == prac_pkg::S_SRCH,
                     lo_reg <= hi_reg && hi_reg <= committed_reg,
                     "search window outside committed table")
    `PRAC_ASSERT_NOW(a_idle_session, !loading_reg,
                     pend_reg == '0 && err_reg == prac_pkg::ST_OK,
                     "load state left over outside a session")

endmodule

// ===== tb/sv/protected_range_access_checker_tb.sv =====
// Self-checking bench for protected_range_access_checker: directed table, full-table loads,
// then randomised load sessions, checks and depth traffic under several task limits.
// Depends on prac_pkg and the checker RTL.
`timescale 1ns / 1ps

module protected_range_access_checker_tb;

    import prac_pkg::*;

    localparam logic [3:0]  REQ_UNUSED_LO  = 4'd9;
    localparam logic [3:0]  REQ_UNUSED_HI  = 4'd15;
    localparam logic [63:0] ONES64         = '1;
    localparam int          DIR_ROWS       = 30;
    localparam int          ITEMS_TOTAL    = 1350;
    localparam int          LIMIT_PHASES   = 5;
    localparam int          WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [3:0]  req;
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] rend;
        logic [15:0] dep;
    } access_req_t;

    typedef struct packed {
        logic                   allowed;
        logic [2:0]             status;
        logic [15:0]            depth;
        logic [COUNT_OUT_W-1:0] count;
    } verdict_t;

    typedef struct packed {
        access_req_t req;
        logic        typed;
        verdict_t    want;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [3:0]  req_type  = '0;
    logic [63:0] address   = '0;
    logic [63:0] length    = '0;
    logic [63:0] range_end = '0;
    logic [15:0] depth_in  = '0;
    logic        cfg_valid = 1'b0;
    logic [63:0] cfg_data  = '0;
    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic        allowed;
    logic [2:0]  status;
    logic [15:0] depth_out;
    logic [COUNT_OUT_W-1:0] range_count;

    // predictor state
    logic [63:0] limit_reg = TASK_LIMIT_RST;
    logic [63:0] tbl_start [MAX_RANGES_DEF];
    logic [63:0] tbl_end [MAX_RANGES_DEF];
    logic [6:0]  live_count     = '0;
    logic [6:0]  staged_count   = '0;
    logic [63:0] last_raw_start = '0;
    logic [2:0]  stage_err      = ST_OK;
    logic        staging        = 1'b0;
    logic [15:0] nest_depth     = '0;

    verdict_t awaited [$];
    int       mismatches   = 0;
    int       items_sent   = 0;
    int       results_seen = 0;
    int       idle_cycles  = 0;
    int       status_hits [5] = '{0, 0, 0, 0, 0};
    bit       no_gaps      = 1'b0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{REQ_FINISH,    64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_NONE,     16'h0,    7'd0}},
        '{'{REQ_RAW_CHK,   64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b1, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_RAW_CHK,   TASK_LIMIT_RST, 64'h1,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_RAW_CHK,   64'h0,          ONES64,     64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_EXIT,      64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'hFFFF, 7'd0}},
        '{'{REQ_ENTER,     64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_RESUME,    64'h0,          64'h0,      64'h0,      16'hFFFF},
          1'b1, '{1'b0, ST_OK,       16'hFFFF, 7'd0}},
        '{'{REQ_SUSPEND,   64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'hFFFF, 7'd0}},
        '{'{REQ_RESUME,    64'h0,          64'h0,      64'h0,      16'h5},
          1'b1, '{1'b0, ST_OK,       16'h5,    7'd0}},
        '{'{REQ_RST_DEPTH, 64'h0,          64'h0,      64'h0,      16'hFFFF},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_UNUSED_LO, ONES64,         ONES64,     ONES64,     16'hFFFF},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_UNUSED_HI, 64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_GATED_CHK, ONES64,         64'h5,      64'h0,      16'h0},
          1'b1, '{1'b1, ST_OK,       16'h0,    7'd0}},
        '{'{REQ_LOAD,      64'h1000,       64'h0,      64'h2000,   16'h0},
          1'b1, '{1'b0, ST_OK,       16'h0,    7'd1}},
        '{'{REQ_LOAD,      64'h1800,       64'h0,      64'h3000,   16'h0}, 1'b0, '0},
        '{'{REQ_LOAD,      64'h3000,       64'h0,      64'h3100,   16'h0}, 1'b0, '0},
        '{'{REQ_LOAD,      64'h5000,       64'h0,      64'h6000,   16'h0}, 1'b0, '0},
        '{'{REQ_FINISH,    64'h0,          64'h0,      64'h0,      16'h0}, 1'b0, '0},
        '{'{REQ_GATED_CHK, 64'h2FFF,       64'h1,      64'h0,      16'h0}, 1'b0, '0},
        '{'{REQ_ENTER,     64'h0,          64'h0,      64'h0,      16'h0}, 1'b0, '0},
        '{'{REQ_GATED_CHK, 64'h2FFF,       64'h1,      64'h0,      16'h0}, 1'b0, '0},
        '{'{REQ_RAW_CHK,   64'h3100,       64'h1F00,   64'h0,      16'h0}, 1'b0, '0},
        '{'{REQ_LOAD,      64'h10,         64'h0,      64'h10,     16'h0},
          1'b1, '{1'b0, ST_EMPTY,    16'h1,    7'd0}},
        '{'{REQ_LOAD,      64'h20,         64'h0,      64'h30,     16'h0},
          1'b1, '{1'b0, ST_EMPTY,    16'h1,    7'd0}},
        '{'{REQ_FINISH,    64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_EMPTY,    16'h1,    7'd0}},
        '{'{REQ_LOAD,      64'h200,        64'h0,      64'h300,    16'h0}, 1'b0, '0},
        '{'{REQ_LOAD,      64'h100,        64'h0,      64'h180,    16'h0},
          1'b1, '{1'b0, ST_UNSORTED, 16'h1,    7'd1}},
        '{'{REQ_FINISH,    64'h0,          64'h0,      64'h0,      16'h0},
          1'b1, '{1'b0, ST_UNSORTED, 16'h1,    7'd0}},
        '{'{REQ_LOAD,      ONES64 - 64'h1, 64'h0,      ONES64,     16'h0}, 1'b0, '0},
        '{'{REQ_FINISH,    64'h0,          64'h0,      64'h0,      16'h0}, 1'b0, '0}
    };

    protected_range_access_checker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .address     (address),
        .length      (length),
        .range_end   (range_end),
        .depth_in    (depth_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .allowed     (allowed),
        .status      (status),
        .depth_out   (depth_out),
        .range_count (range_count)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // zero length passes; beyond the limit fails; else binary search for an overlap
    function automatic logic access_clear(input logic [63:0] a, input logic [63:0] n);
        int          lo;
        int          hi;
        int          mid;
        logic [63:0] last;
        if (n == 0)
            return 1'b1;
        if (a >= limit_reg || n > limit_reg - a)
            return 1'b0;
        last = a + n;
        lo   = 0;
        hi   = int'(live_count);
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (tbl_end[mid] <= a)
                lo = mid + 1;
            else
                hi = mid;
        end
        return (lo == int'(live_count)) || (tbl_start[lo] >= last);
    endfunction

    function automatic verdict_t predict_verdict(input access_req_t it);
        verdict_t    v;
        logic [15:0] held;
        v    = '0;
        held = nest_depth;
        case (it.req)
            REQ_LOAD:
            begin
                if (!staging)
                begin
                    staging        = 1'b1;
                    staged_count   = '0;
                    stage_err      = ST_OK;
                    last_raw_start = '0;
                    live_count     = '0;
                end
                if (stage_err == ST_OK)
                begin
                    if (it.addr >= it.rend)
                        stage_err = ST_EMPTY;
                    else if (staged_count != 0 && last_raw_start > it.addr)
                        stage_err = ST_UNSORTED;
                    else if (staged_count != 0 && tbl_end[staged_count - 1] >= it.addr)
                    begin
                        if (it.rend > tbl_end[staged_count - 1])
                            tbl_end[staged_count - 1] = it.rend;
                        last_raw_start = it.addr;
                    end
                    else if (staged_count >= MAX_RANGES_DEF)
                        stage_err = ST_FULL;
                    else
                    begin
                        tbl_start[staged_count] = it.addr;
                        tbl_end[staged_count]   = it.rend;
                        staged_count            = staged_count + 7'd1;
                        last_raw_start          = it.addr;
                    end
                end
                v.status = stage_err;
            end
            REQ_FINISH:
            begin
                if (stage_err != ST_OK)
                begin
                    v.status   = stage_err;
                    live_count = '0;
                end
                else if (staged_count == 0)
                begin
                    v.status   = ST_NONE;
                    live_count = '0;
                end
                else
                    live_count = staged_count;
                staged_count = '0;
                stage_err    = ST_OK;
                staging      = 1'b0;
            end
            REQ_ENTER:     nest_depth = nest_depth + 16'd1;
            REQ_EXIT:      nest_depth = nest_depth - 16'd1;
            REQ_SUSPEND:   nest_depth = '0;
            REQ_RESUME:    nest_depth = it.dep;
            REQ_RST_DEPTH: nest_depth = '0;
            REQ_GATED_CHK: v.allowed = (nest_depth == 0) || access_clear(it.addr, it.len);
            REQ_RAW_CHK:   v.allowed = access_clear(it.addr, it.len);
            default: ;
        endcase
        v.depth = (it.req == REQ_SUSPEND) ? held : nest_depth;
        v.count = (it.req == REQ_LOAD) ? staged_count : live_count;
        return v;
    endfunction

    task automatic issue(input access_req_t it, input logic typed, input verdict_t want);
        int       gap;
        logic     ignored;
        verdict_t pred;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        req_type  <= it.req;
        address   <= it.addr;
        length    <= it.len;
        range_end <= it.rend;
        depth_in  <= it.dep;
        // hold until the request transfer
        do
            @(posedge clk);
        while (busy);
        ignored = (it.req == REQ_LOAD) && staging && (stage_err != ST_OK);
        pred    = predict_verdict(it);
        awaited.push_back(typed ? want : pred);
        if (!ignored)
            items_sent++;
        if (it.req == REQ_LOAD || it.req == REQ_FINISH)
            status_hits[pred.status]++;
    endtask

    task automatic send(input logic [3:0] rq, input logic [63:0] a, input logic [63:0] n,
                        input logic [63:0] e, input logic [15:0] d);
        issue('{rq, a, n, e, d}, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [63:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        verdict_t ref_v;
        if (rst_n && done)
        begin
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end
            else
            begin
                ref_v = awaited.pop_front();
                if (allowed !== ref_v.allowed)
                begin
                    $error("allowed: expected %0h, got %0h", ref_v.allowed, allowed);
                    mismatches++;
                end
                if (status !== ref_v.status)
                begin
                    $error("status: expected %0h, got %0h", ref_v.status, status);
                    mismatches++;
                end
                if (depth_out !== ref_v.depth)
                begin
                    $error("depth_out: expected %0h, got %0h", ref_v.depth, depth_out);
                    mismatches++;
                end
                if (range_count !== ref_v.count)
                begin
                    $error("range_count: expected %0h, got %0h", ref_v.count, range_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("protected_range_access_checker_tb NOT OK");
        $finish;
    end

    initial
    begin
        int          ph;
        int          k;
        int          n;
        int          s;
        int          idx;
        int          pick;
        int          goal;
        logic [3:0]  rq;
        logic [63:0] base;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] sa;
        logic [63:0] len;
        logic [63:0] limits [LIMIT_PHASES];

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            issue(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

        // exactly full table, then one range too many
        for (s = 0; s < 2; s++)
        begin
            for (k = 0; k < MAX_RANGES_DEF + s; k++)
                send(REQ_LOAD, 64'(k) * 64'h100, '0, 64'(k) * 64'h100 + 64'h80, '0);
            send(REQ_FINISH, '0, '0, '0, '0);
            for (k = 0; k < 10; k++)
                send(REQ_RAW_CHK, 64'($urandom_range(0, MAX_RANGES_DEF * 'h100)),
                     64'($urandom_range(1, 'h100)), '0, '0);
        end

        limits[0] = ONES64;
        limits[1] = 64'd1;
        limits[2] = rnd64() | 64'd1;
        limits[3] = 64'h1_0000;
        limits[4] = TASK_LIMIT_RST;

        for (ph = 0; ph < LIMIT_PHASES; ph++)
        begin
            write_limit(limits[ph]);
            goal = items_sent + (ITEMS_TOTAL - items_sent) / (LIMIT_PHASES - ph);
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 49) == 0)
                    no_gaps = !no_gaps;
                if ($urandom_range(0, 99) == 0)
                    drain();
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 10);
                    case ($urandom_range(0, 3))
                        0, 1:    base = 64'($urandom_range(0, 'hFFFF));
                        2:       base = limit_reg - 64'($urandom_range(0, 'h4000));
                        default: base = rnd64();
                    endcase
                    a = base;
                    for (k = 0; k < n; k++)
                    begin
                        if (k > 0)
                            a = a + 64'($urandom_range(0, 'h300));
                        e  = a + 64'($urandom_range(1, 'h200));
                        sa = a;
                        case ($urandom_range(0, 39))
                            0:       e  = a - 64'($urandom_range(0, 3));
                            1:       sa = a - 64'($urandom_range(1, 'h100));
                            default: ;
                        endcase
                        send(REQ_LOAD, sa, rnd64(), e, 16'($urandom));
                    end
                    if ($urandom_range(0, 9) != 0)
                        send(REQ_FINISH, rnd64(), rnd64(), rnd64(), 16'($urandom));
                end
                else if (pick < 75)
                begin
                    n = $urandom_range(1, 12);
                    for (k = 0; k < n; k++)
                    begin
                        if (live_count != 0 && $urandom_range(0, 4) != 0)
                        begin
                            idx = $urandom_range(0, int'(live_count) - 1);
                            a   = ($urandom_range(0, 1) == 0) ? tbl_start[idx] : tbl_end[idx];
                            a   = a - 64'h40 + 64'($urandom_range(0, 'h80));
                        end
                        else if ($urandom_range(0, 1) == 0)
                            a = 64'($urandom_range(0, 'hFFFF));
                        else
                            a = rnd64();
                        case ($urandom_range(0, 6))
                            0:       len = '0;
                            1:       len = rnd64();
                            2:       len = limit_reg - a;
                            default: len = 64'($urandom_range(1, 'h100));
                        endcase
                        rq = ($urandom_range(0, 1) == 0) ? REQ_GATED_CHK : REQ_RAW_CHK;
                        send(rq, a, len, rnd64(), 16'($urandom));
                    end
                end
                else if (pick < 90)
                begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 7))
                            0, 1:    rq = REQ_ENTER;
                            2, 3:    rq = REQ_EXIT;
                            4:       rq = REQ_SUSPEND;
                            5:       rq = REQ_RESUME;
                            6:       rq = REQ_RST_DEPTH;
                            default: rq = REQ_GATED_CHK;
                        endcase
                        send(rq, rnd64(), 64'($urandom_range(0, 'h40)), rnd64(),
                             16'($urandom));
                    end
                end
                else
                    send(4'($urandom_range(0, 15)), rnd64(), rnd64(), rnd64(),
                         16'($urandom));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (awaited.size() != 0)
        begin
            $error("%0d results never arrived", awaited.size());
            mismatches++;
        end

        $display("Sent %0d requests, checked %0d results over %0d task limit settings.",
                 items_sent, results_seen, LIMIT_PHASES + 1);
        $display("Load outcomes: ok %0d, empty %0d, unsorted %0d, full %0d, none %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatches == 0)
            $display("protected_range_access_checker_tb OK");
        else
            $display("protected_range_access_checker_tb NOT OK");
        $finish;
    end

endmodule
